// File: hdl/scanline_span_depth_buffer_macros.svh
// assertion macros for the span depth buffer checker
`ifndef SCANLINE_SPAN_DEPTH_BUFFER_MACROS_SVH
`define SCANLINE_SPAN_DEPTH_BUFFER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SSDB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SSDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/ssdb_pkg.sv
// ----------------------------------------------------------------------------
// ssdb_pkg
// shared constants, types and helpers of the span depth buffer
// ----------------------------------------------------------------------------
package ssdb_pkg;

  localparam int unsigned Rows     = 256;
  localparam int unsigned RowAw    = $clog2(Rows);

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  localparam logic [15:0] DepthFar     = 16'h7fff;
  localparam logic [14:0] PrioReset    = 15'd192;
  localparam logic [1:0]  AddrPrioDepth = 2'd0;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture item
    logic div_start; // start both divisions
    logic walk_init; // load accumulators and row counter
    logic walk_step; // walk one phase of a row
    logic clr_init;
    logic clr_step;
    logic read_req;  // issue memory read
    logic out_load;  // load result register
  } ssdb_cmd_t;

  typedef struct packed {
    logic backward;
    logic div_done;
    logic walk_last;
    logic clr_last;
  } ssdb_sts_t;

endpackage

// File: hdl/ssdb_in_if.sv
// ----------------------------------------------------------------------------
// ssdb_in_if
// input channel carrying one item word
// ----------------------------------------------------------------------------
interface ssdb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [15:0] x_start;
  logic signed [15:0] x_end;
  logic [7:0]        y_start;
  logic [7:0]        y_end;
  logic signed [15:0] z_start;
  logic signed [15:0] z_end;
  logic [1:0]        base_color;
  logic [7:0]        row;
  modport source (output valid, func, x_start, x_end, y_start, y_end, z_start, z_end,
                  base_color, row, input ready);
  modport sink (input valid, func, x_start, x_end, y_start, y_end, z_start, z_end,
                base_color, row, output ready);
endinterface

// File: hdl/ssdb_out_if.sv
// ----------------------------------------------------------------------------
// ssdb_out_if
// output channel carrying one result word
// ----------------------------------------------------------------------------
interface ssdb_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] row_depth;
  logic signed [15:0] row_width;
  logic [6:0]        row_color;
  logic              behind_flag;
  modport source (output valid, row_depth, row_width, row_color, behind_flag, input ready);
  modport sink (input valid, row_depth, row_width, row_color, behind_flag, output ready);
endinterface

// File: hdl/ssdb_div.sv
// ----------------------------------------------------------------------------
// ssdb_div
// restoring divider, one quotient bit a cycle, saturated to 16 bits
// ----------------------------------------------------------------------------
module ssdb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [16:0]  diff_i,   // v_end - v_start
  input  logic [7:0]          den_i,    // row count, nonzero
  output logic                done_o,
  output logic signed [15:0]  quot_o
);
  import ssdb_pkg::*;

  localparam int unsigned NumW = 25; // |diff| << 8 fits 25 bits
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [8:0]      rem_q, rem_d;
  logic [7:0]      den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [16:0]     mag;
  logic [8:0]      trial;
  logic [NumW:0]   sq;

  always_comb begin
    mag    = diff_i[16] ? 17'(-diff_i) : diff_i;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[7:0], num_q[NumW-1]};
    if (start_i) begin
      num_d  = {mag, 8'd0};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = diff_i[16];
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // signed saturate
  always_comb begin
    sq = neg_q ? (NumW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > NumW'(32767))       quot_o = 16'sh7fff;
    else if (neg_q && quo_q > NumW'(32768))   quot_o = -16'sh8000;
    else                                      quot_o = sq[15:0];
  end

  assign done_o = !busy_q && !start_i;
endmodule

// File: hdl/ssdb_datapath.sv
// ----------------------------------------------------------------------------
// ssdb_datapath
// item registers, dividers, accumulators, row memories and result register
// ----------------------------------------------------------------------------
module ssdb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssdb_pkg::ssdb_cmd_t cmd_i,
  output ssdb_pkg::ssdb_sts_t sts_o,
  input  logic [14:0]         prio_i,
  input  logic [1:0]          func_i,
  input  logic signed [15:0]  x_start_i,
  input  logic signed [15:0]  x_end_i,
  input  logic [7:0]          y_start_i,
  input  logic [7:0]          y_end_i,
  input  logic signed [15:0]  z_start_i,
  input  logic signed [15:0]  z_end_i,
  input  logic [1:0]          base_color_i,
  input  logic [7:0]          row_i,
  output logic signed [15:0]  row_depth_o,
  output logic signed [15:0]  row_width_o,
  output logic [6:0]          row_color_o,
  output logic                behind_flag_o
);
  import ssdb_pkg::*;

  logic [1:0]         func_q;
  logic signed [15:0] xs_q, xe_q, zs_q, ze_q;
  logic [7:0]         ys_q, ye_q, row_q;
  logic [1:0]         base_q;
  logic [31:0]        xa_q, za_q;
  logic [8:0]         y_q;
  logic [7:0]         left_q;
  logic [6:0]         code_q;
  logic [RowAw-1:0]   clr_q;
  logic signed [15:0] qx, qz;
  logic               dx_done, dz_done;
  logic               started_q;

  logic [15:0] dmem [Rows];
  logic [15:0] wmem [Rows];
  logic [6:0]  cmem [Rows];
  logic [15:0] rd_d_q, rd_w_q;
  logic [6:0]  rd_c_q;
  logic        rd_far_q;
  logic [15:0] cur_d_q;
  logic        cur_ok_q;

  logic [7:0]  n;
  logic signed [12:0] sh;
  logic signed [12:0] shabs;
  logic signed [5:0]  shade;
  logic               walk_ph_q;

  assign n = ye_q - ys_q;

  ssdb_div u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .diff_i(17'(xe_q) - 17'(xs_q)), .den_i(n), .done_o(dx_done), .quot_o(qx));
  ssdb_div u_div_z (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .diff_i(17'(ze_q) - 17'(zs_q)), .den_i(n), .done_o(dz_done), .quot_o(qz));

  // magnitude of the steepest step (2048) needs the extra bit
  always_comb begin
    sh    = 13'(qz >>> 4);
    shabs = sh[12] ? -sh : sh;
    if (shabs > 13'sd24)  shade = -6'sd12;
    else                  shade = 6'(13'sd12 - shabs);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i; xs_q <= x_start_i; xe_q <= x_end_i;
      ys_q <= y_start_i; ye_q <= y_end_i; zs_q <= z_start_i; ze_q <= z_end_i;
      base_q <= base_color_i; row_q <= row_i;
    end
    if (cmd_i.walk_init) begin
      xa_q   <= {xs_q, 16'd0};
      za_q   <= {zs_q, 16'd0};
      y_q    <= {1'b0, ys_q};
      left_q <= n;
      code_q <= 7'({base_q, 5'd0} + 7'd16 + 7'(signed'(shade)));
    end else if (cmd_i.walk_step && walk_ph_q) begin
      xa_q   <= xa_q + {qx[15], qx[15], qx[15], qx[15], qx[15], qx[15], qx[15], qx[15], qx, 8'd0};
      za_q   <= za_q + {qz[15], qz[15], qz[15], qz[15], qz[15], qz[15], qz[15], qz[15], qz, 8'd0};
      y_q    <= y_q + 1'b1;
      left_q <= left_q - 1'b1;
    end
  end

  // walk: phase 0 reads stored depth, phase 1 compares, writes and advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_ph_q <= 1'b0;
      clr_q     <= '0;
      started_q <= 1'b0;
    end else begin
      started_q <= cmd_i.div_start;
      if (cmd_i.walk_init) walk_ph_q <= 1'b0;
      else if (cmd_i.walk_step) walk_ph_q <= !walk_ph_q;
      if (cmd_i.clr_init) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_d_q  <= dmem[y_q[RowAw-1:0]];
    cur_ok_q <= (y_q < 9'(Rows));
    if (cmd_i.walk_step && walk_ph_q) begin
      if (cur_ok_q && $signed(cur_d_q) > $signed(za_q[31:16])) begin
        dmem[y_q[RowAw-1:0]] <= za_q[31:16];
        wmem[y_q[RowAw-1:0]] <= xa_q[31:16];
        cmem[y_q[RowAw-1:0]] <= code_q;
      end
    end else if (cmd_i.clr_step) begin
      dmem[clr_q] <= DepthFar;
      wmem[clr_q] <= '0;
      cmem[clr_q] <= '0;
    end
    if (cmd_i.read_req) begin
      rd_d_q   <= dmem[row_q[RowAw-1:0]];
      rd_w_q   <= wmem[row_q[RowAw-1:0]];
      rd_c_q   <= cmem[row_q[RowAw-1:0]];
      rd_far_q <= ({1'b0, row_q} >= 9'(Rows));
    end
    if (cmd_i.out_load) begin
      if (func_q == FUNC_READ) begin
        row_depth_o   <= rd_far_q ? DepthFar : rd_d_q;
        row_width_o   <= rd_far_q ? '0 : rd_w_q;
        row_color_o   <= rd_far_q ? '0 : rd_c_q;
        behind_flag_o <= rd_far_q ? (DepthFar > 16'(prio_i))
                                  : ($signed(rd_d_q) > $signed({1'b0, prio_i}));
      end else begin
        row_depth_o <= '0; row_width_o <= '0; row_color_o <= '0; behind_flag_o <= 1'b0;
      end
    end
  end

  assign sts_o.backward  = (ys_q >= ye_q);
  assign sts_o.div_done  = dx_done && dz_done && !started_q;
  assign sts_o.walk_last = walk_ph_q && (left_q == 8'd1);
  assign sts_o.clr_last  = (clr_q == RowAw'(Rows - 1));
endmodule

// File: hdl/ssdb_ctrl.sv
// ----------------------------------------------------------------------------
// ssdb_ctrl
// sequencer for clear, draw and read items and the output handshake
// ----------------------------------------------------------------------------
module ssdb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          func_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssdb_pkg::ssdb_cmd_t cmd_o,
  input  ssdb_pkg::ssdb_sts_t sts_i
);
  import ssdb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECODE, S_DIV, S_WALK, S_CLEAR, S_READ, S_RESULT
  } state_e;

  state_e state_q;
  logic [1:0] func_q;
  logic       busy_out_q;

  // no new word while the result word waits
  assign in_ready_o  = (state_q == S_IDLE) && !busy_out_q;
  assign out_valid_o = busy_out_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    unique case (state_q)
      S_INIT:   cmd_o.clr_step  = 1'b1;
      S_DECODE: begin
        cmd_o.div_start = (func_q == FUNC_DRAW) && !sts_i.backward;
        cmd_o.clr_init  = (func_q == FUNC_CLEAR);
      end
      S_DIV:    cmd_o.walk_init = sts_i.div_done;
      S_WALK:   cmd_o.walk_step = 1'b1;
      S_CLEAR:  cmd_o.clr_step  = 1'b1;
      S_READ:   cmd_o.read_req  = 1'b1;
      S_RESULT: cmd_o.out_load  = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      func_q     <= FUNC_NOP;
      busy_out_q <= 1'b0;
    end else begin
      if (busy_out_q && out_ready_i) busy_out_q <= 1'b0;
      unique case (state_q)
        S_INIT:   if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE: if (in_valid_i && in_ready_o) begin
          func_q  <= func_i;
          state_q <= S_DECODE;
        end
        S_DECODE: begin
          case (func_q)
            FUNC_CLEAR: state_q <= S_CLEAR;
            FUNC_DRAW:  state_q <= sts_i.backward ? S_RESULT : S_DIV;
            FUNC_READ:  state_q <= S_READ;
            default:    state_q <= S_RESULT;
          endcase
        end
        S_DIV:    if (sts_i.div_done) state_q <= S_WALK;
        S_WALK:   if (sts_i.walk_last) state_q <= S_RESULT;
        S_CLEAR:  if (sts_i.clr_last) state_q <= S_RESULT;
        S_READ:   state_q <= S_RESULT;
        S_RESULT: begin
          busy_out_q <= 1'b1;
          state_q    <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/scanline_span_depth_buffer.sv
// ----------------------------------------------------------------------------
// scanline_span_depth_buffer
// per-row depth buffer that rasterizes face edges into 256 rows
// ----------------------------------------------------------------------------
// one word in, one word out. clear sweeps all rows, one row a cycle; draw
// runs two serial dividers side by side, then walks the edge a row at a time
// (read the stored depth, then compare and write), and read fetches the
// stored row. backward faces and unused codes go straight to a zero result.
// the block works on one word at a time; the result register is handed over
// before a new word is taken. after reset the store is swept to far depth,
// width 0 and colour 0, one row a cycle, so the input stays not ready until
// the sweep is done
module scanline_span_depth_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  ssdb_in_if.sink        in_if,
  ssdb_out_if.source     out_if,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ssdb_pkg::*;

  ssdb_cmd_t   cmd;
  ssdb_sts_t   sts;
  logic [14:0] prio_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrPrioDepth) ? {17'd0, prio_q} : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= PrioReset;
    end else if (psel && penable && pwrite && paddr == AddrPrioDepth) begin
      prio_q <= pwdata[14:0];
    end
  end

  ssdb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .func_i(in_if.func), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts));

  ssdb_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .prio_i(prio_q),
    .func_i(in_if.func), .x_start_i(in_if.x_start), .x_end_i(in_if.x_end),
    .y_start_i(in_if.y_start), .y_end_i(in_if.y_end),
    .z_start_i(in_if.z_start), .z_end_i(in_if.z_end),
    .base_color_i(in_if.base_color), .row_i(in_if.row),
    .row_depth_o(out_if.row_depth), .row_width_o(out_if.row_width),
    .row_color_o(out_if.row_color), .behind_flag_o(out_if.behind_flag));
endmodule

// File: hdl/ssdb_checker.sv
// ----------------------------------------------------------------------------
// ssdb_checker
// port-level checks of the span depth buffer
// ----------------------------------------------------------------------------
`include "scanline_span_depth_buffer_macros.svh"
module ssdb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);
  `SSDB_ASSERT_IMP(a_no_take_while_full, clk_i, rst_ni, out_valid, !in_ready)
  `SSDB_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `SSDB_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `SSDB_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind scanline_span_depth_buffer ssdb_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .pready);
